// File: rtl/command_line_field_tokenizer_core_macros.svh
// Assertion macros for the command line field tokenizer.
`ifndef COMMAND_LINE_FIELD_TOKENIZER_CORE_MACROS_SVH
`define COMMAND_LINE_FIELD_TOKENIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold in the same cycle whenever the condition holds.
`define CLFT_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
// Property that must hold in the cycle after the condition.
`define CLFT_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define CLFT_ASSERT_IMP(name, pre, post, msg)
`define CLFT_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

// File: rtl/clft_pkg.sv
// Shared types and constants of the command line field tokenizer.
package clft_pkg;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // field kinds
   localparam logic [1:0] KIND_LOWER   = 2'd0;
   localparam logic [1:0] KIND_UPPER   = 2'd1;
   localparam logic [1:0] KIND_NUMERIC = 2'd2;
   localparam logic [1:0] KIND_FLOAT   = 2'd3;

   // widths wide enough for any position or field count in range
   localparam int POS_MAX_W = 8;
   localparam int CNT_MAX_W = 5;

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // classified character
   typedef struct packed {
      logic [7:0] ch;
      logic       is_zero;
      logic       is_delim;
      logic       is_lower;
      logic       is_upper;
      logic       is_digit;
      logic       is_dot;
      logic       is_opener;
   } char_class_type;

   // queue status seen by the top level
   typedef struct packed {
      logic               push_ready;
      logic               pop_valid;
      logic [Q_CNT_W-1:0] count;
   } queue_status_type;

   // one result beat
   typedef struct packed {
      logic        has_field;
      logic [2:0]  field_number;
      logic [6:0]  field_start;
      logic [6:0]  field_length;
      logic [1:0]  field_kind;
      logic [31:0] int_value;
      logic        int_valid;
      logic        line_end;
      logic [3:0]  field_count;
      logic        too_many_fields;
   } result_type;

endpackage

// File: rtl/clft_front.sv
// Front stage: accepts characters and registers their classification.
module clft_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_ch,
   output logic                      push_valid,
   input  logic                      push_ready,
   output clft_pkg::char_class_type  push_item
);

   logic                     front_valid_ff;
   logic                     front_valid_in;
   clft_pkg::char_class_type front_item_ff;
   clft_pkg::char_class_type front_item_in;
   logic                     accept;

   // handshake: the stage frees up whenever its beat moves into the queue
   assign req_ready  = !front_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = front_valid_ff;
   assign push_item  = front_item_ff;

   // character classification
   always_comb begin
      front_item_in.ch        = req_ch;
      front_item_in.is_zero   = (req_ch == clft_pkg::CH_NUL);
      front_item_in.is_delim  = (req_ch == clft_pkg::CH_SPACE) ||
                                (req_ch == clft_pkg::CH_COMMA);
      front_item_in.is_lower  = req_ch inside {[8'h61:8'h7A]};
      front_item_in.is_upper  = req_ch inside {[8'h41:8'h5A]};
      front_item_in.is_digit  = req_ch inside {[8'h30:8'h39]};
      front_item_in.is_dot    = (req_ch == clft_pkg::CH_DOT);
      front_item_in.is_opener = front_item_in.is_lower || front_item_in.is_upper ||
                                front_item_in.is_digit || front_item_in.is_dot ||
                                (req_ch == clft_pkg::CH_MINUS);
   end

   always_comb begin
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

endmodule

// File: rtl/clft_queue.sv
// Two-entry queue between the classify front and the tokenizing back.
module clft_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  clft_pkg::char_class_type   push_item,
   input  logic                       pop,
   output clft_pkg::char_class_type   pop_item,
   output clft_pkg::queue_status_type status
);

   clft_pkg::char_class_type              entry_ff [clft_pkg::Q_DEPTH];
   logic [clft_pkg::Q_PTR_W-1:0]          wr_ptr_ff;
   logic [clft_pkg::Q_PTR_W-1:0]          wr_ptr_in;
   logic [clft_pkg::Q_PTR_W-1:0]          rd_ptr_ff;
   logic [clft_pkg::Q_PTR_W-1:0]          rd_ptr_in;
   logic [clft_pkg::Q_CNT_W-1:0]          count_ff;
   logic [clft_pkg::Q_CNT_W-1:0]          count_in;
   logic                                  push;
   logic                                  do_pop;

   assign status.push_ready = (count_ff != clft_pkg::Q_CNT_W'(clft_pkg::Q_DEPTH));
   assign status.pop_valid  = (count_ff != '0);
   assign status.count      = count_ff;
   assign push     = push_valid && status.push_ready;
   assign do_pop   = pop && status.pop_valid;
   assign pop_item = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/clft_back.sv
// Back stage: line state, field tracking and the result register.
module clft_back #(
   parameter int LINE_CHARS  = 80,
   parameter int FIELD_LIMIT = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  clft_pkg::char_class_type item,
   output logic                     item_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output clft_pkg::result_type     rsp_item
);

   localparam int POS_W = $clog2(LINE_CHARS);
   localparam int CNT_W = $clog2(FIELD_LIMIT + 1);

   // line state
   logic                 in_field_ff, in_field_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     fields_ff, fields_in;
   logic [POS_W-1:0]     start_ff, start_in;
   logic [1:0]           kind_ff, kind_in;
   logic [31:0]          acc_ff, acc_in;
   logic                 ovf_ff, ovf_in;

   // updated values before the line clear
   logic                 upd_in_field;
   logic [CNT_W-1:0]     upd_fields;
   logic [POS_W-1:0]     upd_start;
   logic [1:0]           upd_kind;
   logic [31:0]          upd_acc;
   logic                 upd_ovf;

   logic                 last;
   logic                 kept;
   logic                 emit;
   logic                 emit_field;
   logic                 emit_end;
   logic                 add_one;
   logic                 clear;

   logic [clft_pkg::POS_MAX_W-1:0] pos_wide;
   logic [clft_pkg::POS_MAX_W-1:0] start_wide;
   logic [clft_pkg::POS_MAX_W-1:0] length_wide;
   logic [clft_pkg::CNT_MAX_W-1:0] fields_wide;
   logic [clft_pkg::CNT_MAX_W-1:0] number_wide;

   clft_pkg::result_type result;
   logic                 rsp_valid_ff, rsp_valid_in;
   clft_pkg::result_type rsp_item_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign item_pop  = item_valid && (!rsp_valid_ff || rsp_ready);

   assign last = (pos_ff >= POS_W'(LINE_CHARS - 1));
   assign kept = in_field_ff && !ovf_ff;

   // per-character state update
   always_comb begin
      upd_in_field = in_field_ff;
      upd_fields   = fields_ff;
      upd_start    = start_ff;
      upd_kind     = kind_ff;
      upd_acc      = acc_ff;
      upd_ovf      = ovf_ff;
      emit         = 1'b0;
      emit_field   = 1'b0;
      emit_end     = 1'b0;
      add_one      = 1'b0;
      clear        = 1'b0;

      if (item.is_zero) begin
         emit       = 1'b1;
         emit_field = kept;
         emit_end   = 1'b1;
         clear      = 1'b1;
      end else begin
         if (in_field_ff) begin
            if (item.is_delim) begin
               if (kept) begin
                  emit       = 1'b1;
                  emit_field = 1'b1;
                  emit_end   = last;
               end
               upd_in_field = 1'b0;
            end else begin
               if (kind_ff == clft_pkg::KIND_NUMERIC && item.is_dot) begin
                  upd_kind = clft_pkg::KIND_FLOAT;
               end else if (kind_ff == clft_pkg::KIND_NUMERIC &&
                            (item.is_lower || item.is_upper)) begin
                  upd_kind = clft_pkg::KIND_LOWER;
               end
               upd_acc = (acc_ff << 3) + (acc_ff << 1) + {24'd0, item.ch} -
                         {24'd0, clft_pkg::CH_ZERO};
            end
         end else if (item.is_opener) begin
            upd_in_field = 1'b1;
            if (ovf_ff || fields_ff >= CNT_W'(FIELD_LIMIT)) begin
               upd_ovf = 1'b1;
            end else begin
               upd_fields = fields_ff + 1'b1;
               upd_start  = pos_ff;
               if (item.is_lower) begin
                  upd_kind = clft_pkg::KIND_LOWER;
               end else if (item.is_upper) begin
                  upd_kind = clft_pkg::KIND_UPPER;
               end else if (item.is_digit) begin
                  upd_kind = clft_pkg::KIND_NUMERIC;
               end else begin
                  upd_kind = clft_pkg::KIND_FLOAT;
               end
               upd_acc = {24'd0, item.ch} - {24'd0, clft_pkg::CH_ZERO};
            end
         end

         // last position closes the line
         if (last) begin
            clear = 1'b1;
            if (!emit) begin
               emit       = 1'b1;
               emit_end   = 1'b1;
               emit_field = upd_in_field && !upd_ovf;
               add_one    = 1'b1;
            end
         end
      end
   end

   // result formatting
   always_comb begin
      pos_wide    = clft_pkg::POS_MAX_W'(pos_ff);
      start_wide  = clft_pkg::POS_MAX_W'(upd_start);
      length_wide = pos_wide - start_wide + {{(clft_pkg::POS_MAX_W-1){1'b0}}, add_one};
      fields_wide = clft_pkg::CNT_MAX_W'(upd_fields);
      number_wide = fields_wide - 1'b1;

      result                 = '0;
      result.line_end        = emit_end;
      result.field_count     = fields_wide[3:0];
      result.too_many_fields = upd_ovf;
      if (emit_field) begin
         result.has_field    = 1'b1;
         result.field_number = number_wide[2:0];
         result.field_start  = start_wide[6:0];
         result.field_length = length_wide[6:0];
         result.field_kind   = upd_kind;
         if (upd_kind == clft_pkg::KIND_NUMERIC) begin
            result.int_value = upd_acc;
            result.int_valid = 1'b1;
         end
      end
   end

   // next state, cleared at line end
   always_comb begin
      if (clear) begin
         in_field_in = 1'b0;
         pos_in      = '0;
         fields_in   = '0;
         start_in    = '0;
         kind_in     = clft_pkg::KIND_LOWER;
         acc_in      = '0;
         ovf_in      = 1'b0;
      end else begin
         in_field_in = upd_in_field;
         pos_in      = pos_ff + 1'b1;
         fields_in   = upd_fields;
         start_in    = upd_start;
         kind_in     = upd_kind;
         acc_in      = upd_acc;
         ovf_in      = upd_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_field_ff <= 1'b0;
         pos_ff      <= '0;
         fields_ff   <= '0;
         start_ff    <= '0;
         kind_ff     <= clft_pkg::KIND_LOWER;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else if (item_pop) begin
         in_field_ff <= in_field_in;
         pos_ff      <= pos_in;
         fields_ff   <= fields_in;
         start_ff    <= start_in;
         kind_ff     <= kind_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
      end
   end

   // result register
   always_comb begin
      if (item_pop) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && emit) begin
         rsp_item_ff <= result;
      end
   end

endmodule

// File: rtl/command_line_field_tokenizer_core.sv
// Command line field tokenizer: top level with front, queue and back.
//
// Usage: feed one character of a command line per req beat (req_valid,
// req_ready, req_ch). A zero byte, or the character at position
// LINE_CHARS-1, ends the line. Spaces and commas split fields; each field
// that closes gives one rsp beat with its number, start, length, kind and,
// for numeric fields, its decimal value (32-bit wrap). The line end always
// gives a beat with rsp_line_end set. Fields beyond FIELD_LIMIT in a line
// are dropped and flagged in rsp_too_many_fields.
// Path: an accepted req beat passes the classify register, the queue and
// the result register to its rsp beat. Throughput: one character per cycle
// while rsp_ready is high, set by the state update in the back stage.
// Stall: while rsp_ready is low the back stage holds its result, the
// two-entry queue and the front register fill, and req_ready drops after
// at most three more characters are taken.
// Reset: synchronous, active high; clears the line state, the queue and
// all valid flags.
`include "command_line_field_tokenizer_core_macros.svh"
module command_line_field_tokenizer_core #(
   parameter int LINE_CHARS  = 80,
   parameter int FIELD_LIMIT = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_has_field,
   output logic [2:0]         rsp_field_number,
   output logic [6:0]         rsp_field_start,
   output logic [6:0]         rsp_field_length,
   output logic [1:0]         rsp_field_kind,
   output logic signed [31:0] rsp_int_value,
   output logic               rsp_int_valid,
   output logic               rsp_line_end,
   output logic [3:0]         rsp_field_count,
   output logic               rsp_too_many_fields
);

   logic                       push_valid;
   clft_pkg::char_class_type   push_item;
   clft_pkg::char_class_type   pop_item;
   clft_pkg::queue_status_type q_status;
   logic                       pop;
   clft_pkg::result_type       result;

   clft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (q_status.push_ready),
      .push_item  (push_item)
   );

   clft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .pop_item   (pop_item),
      .status     (q_status)
   );

   clft_back #(
      .LINE_CHARS  (LINE_CHARS),
      .FIELD_LIMIT (FIELD_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_status.pop_valid),
      .item       (pop_item),
      .item_pop   (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (result)
   );

   // unpack the result beat
   assign rsp_has_field       = result.has_field;
   assign rsp_field_number    = result.field_number;
   assign rsp_field_start     = result.field_start;
   assign rsp_field_length    = result.field_length;
   assign rsp_field_kind      = result.field_kind;
   assign rsp_int_value       = $signed(result.int_value);
   assign rsp_int_valid       = result.int_valid;
   assign rsp_line_end        = result.line_end;
   assign rsp_field_count     = result.field_count;
   assign rsp_too_many_fields = result.too_many_fields;

   // checks
   `CLFT_ASSERT_IMP(a_empty_only_at_end, rsp_valid && !rsp_has_field, rsp_line_end, "empty beat before line end")
   `CLFT_ASSERT_IMP(a_int_valid_numeric, rsp_valid && rsp_int_valid, rsp_has_field && (rsp_field_kind == clft_pkg::KIND_NUMERIC), "int_valid on non-numeric field")
   `CLFT_ASSERT_IMP(a_queue_bound, 1'b1, q_status.count <= clft_pkg::Q_CNT_W'(clft_pkg::Q_DEPTH), "queue count above depth")
   `CLFT_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready && !reset, rsp_valid && $stable(result), "result changed while stalled")

endmodule
